// ===== rtl/vhcs_pkg.sv =====
// Shared types and constants for the half-grid circular shift block.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package vhcs_pkg;

    localparam int CFG_W    = 6;
    localparam int IDX_W    = 2;
    localparam int SAMPLE_W = 64;

    typedef enum logic [IDX_W-1:0] {
        CFG_SHIFT_ALL = 2'd0,
        CFG_SIZE_X    = 2'd1,
        CFG_SIZE_Y    = 2'd2,
        CFG_SIZE_Z    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_EMIT = 1'b1
    } t_mode;

    typedef struct packed {
        logic             shift_all;
        logic [CFG_W-1:0] size_x;
        logic [CFG_W-1:0] size_y;
        logic [CFG_W-1:0] size_z;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/vhcs_in_if.sv =====
// Input channel: valid/ready handshake with mode and sample payload.
// Depends on vhcs_pkg.
`default_nettype none

interface vhcs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [vhcs_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output mode, output sample_in, input ready);
    modport sink   (input valid, input mode, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/vhcs_out_if.sv =====
// Output channel: valid/ready handshake with shifted sample and last flag.
// Depends on vhcs_pkg.
`default_nettype none

interface vhcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [vhcs_pkg::SAMPLE_W-1:0] sample_out;
    logic                          last;

    modport source (output valid, output sample_out, output last, input ready);
    modport sink   (input valid, input sample_out, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/vhcs_mem.sv =====
// Sample store: one write port, one read port, registered read data.
// Depends on vhcs_pkg.
`default_nettype none

module vhcs_mem #(
    parameter int AW = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [AW-1:0]                 i_waddr,
    input  wire logic [vhcs_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic                          i_re,
    input  wire logic [AW-1:0]                 i_raddr,
    output logic      [vhcs_pkg::SAMPLE_W-1:0] o_rdata
);

    logic [vhcs_pkg::SAMPLE_W-1:0] r_mem [2**AW];
    logic [vhcs_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/vhcs_axis.sv =====
// One axis of a walk: effective size, coordinate fit, half shift and step.
// Depends on vhcs_pkg.
`default_nettype none

module vhcs_axis #(
    parameter  int MAX = 32,
    localparam int CW  = (MAX > 1) ? $clog2(MAX) : 1
) (
    input  wire logic [vhcs_pkg::CFG_W-1:0] i_size,
    input  wire logic [CW-1:0]              i_coord,
    input  wire logic                       i_shift_en,
    input  wire logic                       i_inc,
    output logic      [CW-1:0]              o_shifted,
    output logic      [CW-1:0]              o_next,
    output logic                            o_is_last,
    output logic                            o_carry
);

    localparam int KW = ((CW > vhcs_pkg::CFG_W) ? CW : vhcs_pkg::CFG_W) + 1;

    logic [vhcs_pkg::CFG_W-1:0] g;
    logic [KW-1:0]              g_ext;
    logic [KW-1:0]              fit_ext;
    logic [KW-1:0]              s_sum;
    logic [CW-1:0]              c_fit;

    always_comb begin
        if (i_size == '0) begin
            g = vhcs_pkg::CFG_W'(1);
        end else if (int'(i_size) > MAX) begin
            g = vhcs_pkg::CFG_W'(MAX);
        end else begin
            g = i_size;
        end
        g_ext   = KW'(g);
        c_fit   = (KW'(i_coord) >= g_ext) ? '0 : i_coord;
        fit_ext = KW'(c_fit);
        s_sum   = fit_ext + KW'(g >> 1);
        if (s_sum >= g_ext) begin
            s_sum = s_sum - g_ext;
        end
        o_shifted = i_shift_en ? CW'(s_sum) : c_fit;
        o_is_last = (fit_ext == g_ext - KW'(1));
        o_carry   = i_inc && o_is_last;
        if (!i_inc) begin
            o_next = c_fit;
        end else if (o_is_last) begin
            o_next = '0;
        end else begin
            o_next = CW'(fit_ext + KW'(1));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vhcs_walk.sv =====
// Raster walk over the volume: position registers and per-axis arithmetic.
// Depends on vhcs_pkg and vhcs_axis.
`default_nettype none

module vhcs_walk #(
    parameter  int MAX_X = 32,
    parameter  int MAX_Y = 32,
    parameter  int MAX_Z = 32,
    localparam int CWX   = (MAX_X > 1) ? $clog2(MAX_X) : 1,
    localparam int CWY   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1,
    localparam int CWZ   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1,
    localparam int AW    = CWX + CWY + CWZ
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vhcs_pkg::t_cfg i_cfg,
    input  wire logic           i_shift_en,
    input  wire logic           i_step,
    output logic [AW-1:0]       o_addr,
    output logic                o_last
);

    logic [CWX-1:0] r_x, n_x, sx;
    logic [CWY-1:0] r_y, n_y, sy;
    logic [CWZ-1:0] r_z, n_z, sz;
    logic           lx, ly, lz;
    logic           cx, cy, cz;

    vhcs_axis #(.MAX(MAX_Z)) u_axis_z (
        .i_size(i_cfg.size_z), .i_coord(r_z), .i_shift_en(i_shift_en),
        .i_inc(1'b1), .o_shifted(sz), .o_next(n_z), .o_is_last(lz), .o_carry(cz)
    );

    vhcs_axis #(.MAX(MAX_Y)) u_axis_y (
        .i_size(i_cfg.size_y), .i_coord(r_y), .i_shift_en(i_shift_en && i_cfg.shift_all),
        .i_inc(cz), .o_shifted(sy), .o_next(n_y), .o_is_last(ly), .o_carry(cy)
    );

    vhcs_axis #(.MAX(MAX_X)) u_axis_x (
        .i_size(i_cfg.size_x), .i_coord(r_x), .i_shift_en(i_shift_en && i_cfg.shift_all),
        .i_inc(cy), .o_shifted(sx), .o_next(n_x), .o_is_last(lx), .o_carry(cx)
    );

    assign o_addr = {sx, sy, sz};
    assign o_last = lx && ly && lz && !(cx && !cx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (i_step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/volume_half_circular_shift.sv =====
// Top level of the half-grid circular shift block.
// Depends on vhcs_pkg, vhcs_in_if, vhcs_out_if, vhcs_walk and vhcs_mem.
//
// Usage:
//   i_in carries items: mode load stores sample_in at the next raster position
//   (x outermost, z innermost); mode emit reads the next output position,
//   shifted by half the grid on z, or on all three axes when shift_all is set.
//   o_out carries one result per emit item: sample_out and last, which marks
//   the final sample of a full pass. Both walks wrap after a full volume.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at the
//   next edge; the user makes them only while idle, unchecked by the block.
// Timing:
//   One item per cycle while not stalled. An emit result is valid the cycle
//   after acceptance, set by the registered read of the sample memory.
//   Loads use the memory write port, emits the read port.
// Reset:
//   Clears both walk positions to the origin, the output valid flag, and sets
//   shift_all to 1 and all sizes to 32. Stored samples are not cleared.
// Stall:
//   While a result waits on a low o_out.ready, i_in.ready drops and the
//   result holds in the output register.
`default_nettype none

module volume_half_circular_shift #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    vhcs_in_if.sink                            i_in,
    vhcs_out_if.source                         o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [vhcs_pkg::IDX_W-1:0]    i_cfg_idx,
    input  wire logic [vhcs_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int CWX = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int CWY = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int CWZ = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int AW  = CWX + CWY + CWZ;

    vhcs_pkg::t_cfg r_cfg;
    logic           r_out_valid;
    logic           r_last;
    logic           in_acc;
    logic           do_load;
    logic           do_emit;
    logic [AW-1:0]  load_addr;
    logic [AW-1:0]  emit_addr;
    logic           load_last;
    logic           emit_last;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign do_load    = in_acc && (vhcs_pkg::t_mode'(i_in.mode) == vhcs_pkg::MODE_LOAD);
    assign do_emit    = in_acc && (vhcs_pkg::t_mode'(i_in.mode) == vhcs_pkg::MODE_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_all <= 1'b1;
            r_cfg.size_x    <= vhcs_pkg::CFG_W'(32);
            r_cfg.size_y    <= vhcs_pkg::CFG_W'(32);
            r_cfg.size_z    <= vhcs_pkg::CFG_W'(32);
        end else if (i_cfg_we) begin
            unique case (vhcs_pkg::t_cfg_idx'(i_cfg_idx))
                vhcs_pkg::CFG_SHIFT_ALL: r_cfg.shift_all <= i_cfg_data[0];
                vhcs_pkg::CFG_SIZE_X:    r_cfg.size_x    <= i_cfg_data;
                vhcs_pkg::CFG_SIZE_Y:    r_cfg.size_y    <= i_cfg_data;
                vhcs_pkg::CFG_SIZE_Z:    r_cfg.size_z    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vhcs_walk #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_load_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_shift_en(1'b0),
        .i_step(do_load), .o_addr(load_addr), .o_last(load_last)
    );

    vhcs_walk #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_emit_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_shift_en(1'b1),
        .i_step(do_emit), .o_addr(emit_addr), .o_last(emit_last)
    );

    vhcs_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(do_load), .i_waddr(load_addr), .i_wdata(i_in.sample_in),
        .i_re(do_emit), .i_raddr(emit_addr), .o_rdata(o_out.sample_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_last <= emit_last;
        end else if (do_load) begin
            r_last <= r_last && !load_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.last  = r_last;

endmodule

`default_nettype wire

// ===== rtl/vhcs_chk.sv =====
// Port-level checks for the half-grid circular shift block, bound to the top.
// Depends on vhcs_pkg and volume_half_circular_shift.
`default_nettype none

module vhcs_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_mode,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    logic in_acc;
    logic stalled;

    assign in_acc  = i_in_valid && i_in_ready;
    assign stalled = i_out_valid && !i_out_ready;

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    a_emit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_mode == vhcs_pkg::MODE_EMIT)) |=> i_out_valid)
        else $error("emit item gave no result");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_mode == vhcs_pkg::MODE_LOAD) && !stalled) |=> !i_out_valid)
        else $error("load item gave a result");

    a_ready_only_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> stalled)
        else $error("input blocked without a stalled result");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stalled |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind volume_half_circular_shift vhcs_chk u_vhcs_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_in_mode(i_in.mode),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready)
);

`default_nettype wire
